// ----- rtl/ew3_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ew3_pkg: shared types and constants of the 3x3 white erosion filter
// Frame limits, field widths, command and register codes, and the structs
// that pass between the control, line buffer and window modules.
// ----------------------------------------------------------------------------
package ew3_pkg;

  // Frame limits.
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // Field widths.
  localparam int PIX_W   = 8;
  localparam int CFG_W   = 11;
  localparam int CFG_IDX_W = 2;
  localparam int WID_W   = $clog2(MAX_WIDTH + 1);
  localparam int HGT_W   = $clog2(MAX_HEIGHT + 1);
  localparam int COL_W   = $clog2(MAX_WIDTH);
  localparam int ROW_W   = $clog2(MAX_HEIGHT);
  localparam int PEND_W  = $clog2(MAX_WIDTH + 2);

  // Register reset values.
  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = CFG_IDX_W'(1);

  // Item commands.
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Pixel levels that the erosion rule looks at.
  localparam logic [PIX_W-1:0] PIX_WHITE = PIX_W'(255);
  localparam logic [PIX_W-1:0] PIX_BLACK = PIX_W'(0);

  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic [COL_W-1:0] col_t;

  // One column of the 3x3 window, top to bottom.
  typedef struct packed {
    pixel_t top;
    pixel_t mid;
    pixel_t bot;
  } ew3_col_t;

  // One line buffer word: the pixels one and two rows above at a column.
  typedef struct packed {
    pixel_t older;
    pixel_t newer;
  } ew3_lb_word_t;

  // Line buffer write request.
  typedef struct packed {
    logic         en;
    col_t         addr;
    ew3_lb_word_t data;
  } ew3_wr_t;

  // Word handed from the control stage to the window stage.
  typedef struct packed {
    logic   emit;      // this word produces a result
    logic   write;     // a real pixel goes into the line buffer
    logic   self_fwd;  // the read column is the one this pixel writes
    logic   last;      // final pixel of the frame
    logic   top;       // clamp flags of the output position
    logic   bottom;
    logic   left;
    logic   right;
    col_t   wr_addr;
    pixel_t pixel;
  } ew3_item_t;

endpackage
`default_nettype wire

// ----- rtl/ew3_line_buf.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ew3_line_buf: two-row line buffer
// One word per column holds the pixels one and two rows above. Registered
// read with forwarding of a write that lands in the same cycle.
// ----------------------------------------------------------------------------
module ew3_line_buf (
  input  wire logic                  clk,
  input  wire logic                  rd_en,
  input  wire ew3_pkg::col_t         rd_addr,
  input  wire ew3_pkg::ew3_wr_t      wr,
  output      ew3_pkg::ew3_lb_word_t rd_data
);
  import ew3_pkg::*;

  ew3_lb_word_t row_store [MAX_WIDTH];
  ew3_lb_word_t rd_q;
  ew3_lb_word_t byp_data;
  logic         byp;

  // Memory write and registered read; a colliding write is forwarded.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      row_store[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_q     <= row_store[rd_addr];
      byp      <= wr.en && (wr.addr == rd_addr);
      byp_data <= wr.data;
    end
  end

  assign rd_data = byp ? byp_data : rd_q;

endmodule
`default_nettype wire

// ----- rtl/ew3_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ew3_ctrl: configuration and frame position control
// Holds the size registers, tracks input and output positions and the
// pending count, and issues one word per accepted pixel or draining flush.
// ----------------------------------------------------------------------------
module ew3_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_valid,
  output      logic                        cfg_ready,
  input  wire logic [ew3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ew3_pkg::CFG_W-1:0]   cfg_data,
  input  wire logic                        item_valid,
  input  wire logic                        stage_free,
  input  wire logic                        cmd,
  input  wire ew3_pkg::pixel_t             pixel_in,
  output      logic                        load,
  output      ew3_pkg::ew3_item_t          item,
  output      ew3_pkg::col_t               rd_addr
);
  import ew3_pkg::*;

  logic [CFG_W-1:0]  cfg_width;
  logic [CFG_W-1:0]  cfg_height;
  col_t              in_col;
  logic [ROW_W-1:0]  in_row;
  logic              in_done;
  logic [PEND_W-1:0] pend;
  col_t              out_col;
  logic [ROW_W-1:0]  out_row;

  logic [WID_W-1:0]  eff_w;
  logic [HGT_W-1:0]  eff_h;
  col_t              w_m1;
  logic [ROW_W-1:0]  h_m1;
  logic              single_row;
  logic              acc;
  logic              cfg_wr;
  logic              pix_take;
  logic              pix_emit;
  logic              flush_emit;
  logic              emit;
  logic              last;
  logic              in_wrap;
  logic              out_wrap;

  function automatic col_t next_col(input col_t c, input col_t c_last);
    next_col = (c == c_last) ? '0 : c + COL_W'(1);
  endfunction

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  // Effective frame size: zero acts as one, values above the limit saturate.
  always_comb begin
    if (cfg_width == '0) begin
      eff_w = WID_W'(1);
    end else if (int'(cfg_width) > MAX_WIDTH) begin
      eff_w = WID_W'(MAX_WIDTH);
    end else begin
      eff_w = WID_W'(cfg_width);
    end
    if (cfg_height == '0) begin
      eff_h = HGT_W'(1);
    end else if (int'(cfg_height) > MAX_HEIGHT) begin
      eff_h = HGT_W'(MAX_HEIGHT);
    end else begin
      eff_h = HGT_W'(cfg_height);
    end
  end

  assign w_m1       = COL_W'(eff_w - WID_W'(1));
  assign h_m1       = ROW_W'(eff_h - HGT_W'(1));
  assign single_row = (h_m1 == '0);

  // Item decode.
  assign acc        = item_valid && stage_free;
  assign pix_take   = (cmd == CMD_PIXEL) && !in_done;
  assign pix_emit   = pix_take && (pend >= PEND_W'(eff_w) + PEND_W'(1));
  assign flush_emit = (cmd == CMD_FLUSH) && in_done && (pend != '0);
  assign emit       = pix_emit || flush_emit;
  assign last       = emit && (out_col == w_m1) && (out_row == h_m1);
  assign in_wrap    = (in_col == w_m1);
  assign out_wrap   = (out_col == w_m1);
  assign load       = acc && (pix_take || flush_emit);

  // Column read for the right edge of the window. A single-row frame
  // lags by one pixel less, so its read runs one column ahead.
  always_comb begin
    if (!pix_take) begin
      rd_addr = next_col(out_col, w_m1);
    end else if (single_row) begin
      rd_addr = next_col(in_col, w_m1);
    end else begin
      rd_addr = in_col;
    end
  end

  // Word for the window stage.
  always_comb begin
    item.emit     = emit;
    item.write    = pix_take;
    item.self_fwd = pix_take && single_row && (rd_addr == in_col);
    item.last     = last;
    item.top      = (out_row == '0);
    item.bottom   = (out_row == h_m1);
    item.left     = (out_col == '0);
    item.right    = out_wrap;
    item.wr_addr  = in_col;
    item.pixel    = pixel_in;
  end

  // Size registers and frame counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= WIDTH_RESET;
      cfg_height <= HEIGHT_RESET;
      in_col     <= '0;
      in_row     <= '0;
      in_done    <= 1'b0;
      pend       <= '0;
      out_col    <= '0;
      out_row    <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        CFG_WIDTH: begin
          cfg_width <= cfg_data;
        end
        CFG_HEIGHT: begin
          cfg_height <= cfg_data;
        end
        default: begin
        end
      endcase
      if ((cfg_index == CFG_WIDTH) || (cfg_index == CFG_HEIGHT)) begin
        in_col  <= '0;
        in_row  <= '0;
        in_done <= 1'b0;
        pend    <= '0;
        out_col <= '0;
        out_row <= '0;
      end
    end else if (acc) begin
      if (last) begin
        in_col  <= '0;
        in_row  <= '0;
        in_done <= 1'b0;
        pend    <= '0;
        out_col <= '0;
        out_row <= '0;
      end else begin
        if (pix_take) begin
          in_col <= next_col(in_col, w_m1);
          if (in_wrap) begin
            if (in_row == h_m1) begin
              in_done <= 1'b1;
            end else begin
              in_row <= in_row + ROW_W'(1);
            end
          end
          if (!pix_emit) begin
            pend <= pend + PEND_W'(1);
          end
        end
        if (flush_emit) begin
          pend <= pend - PEND_W'(1);
        end
        if (emit) begin
          out_col <= next_col(out_col, w_m1);
          if (out_wrap) begin
            out_row <= out_row + ROW_W'(1);
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ew3_window.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ew3_window: 3x3 window and erosion rule
// Holds the left and center window columns, forms the right column from the
// line buffer and the new pixel, applies edge clamping and the white rule,
// and drives the result register.
// ----------------------------------------------------------------------------
module ew3_window (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  load,
  input  wire ew3_pkg::ew3_item_t    item_in,
  input  wire ew3_pkg::ew3_lb_word_t rd_data,
  input  wire logic                  result_stall,
  output      logic                  stage_free,
  output      ew3_pkg::ew3_wr_t      wr,
  output      logic                  result_valid,
  output      ew3_pkg::pixel_t       pixel_out,
  output      logic                  frame_last
);
  import ew3_pkg::*;

  logic      b_valid;
  ew3_item_t b_item;
  ew3_col_t  c0;
  ew3_col_t  c1;

  ew3_col_t  rc;
  ew3_col_t  lcol;
  ew3_col_t  rcol;
  logic      out_free;
  logic      b_fire;
  logic      any_black;
  pixel_t    center;
  pixel_t    result;

  // Stage handshake.
  assign out_free   = !result_valid || !result_stall;
  assign b_fire     = b_valid && (!b_item.emit || out_free);
  assign stage_free = !b_valid || b_fire;

  // Right column: two rows up, one row up, and the current pixel.
  always_comb begin
    rc.top = rd_data.older;
    rc.mid = b_item.self_fwd ? b_item.pixel : rd_data.newer;
    rc.bot = b_item.pixel;
  end

  // Line buffer update: shift the column down by one row.
  always_comb begin
    wr.en         = b_fire && b_item.write;
    wr.addr       = b_item.wr_addr;
    wr.data.older = rc.mid;
    wr.data.newer = b_item.pixel;
  end

  // Clamp at the frame edges by replicating the center row or column.
  always_comb begin
    lcol = b_item.left  ? c1 : c0;
    rcol = b_item.right ? c1 : rc;
    if (b_item.top) begin
      lcol.top = lcol.mid;
      rcol.top = rcol.mid;
    end
    if (b_item.bottom) begin
      lcol.bot = lcol.mid;
      rcol.bot = rcol.mid;
    end
  end

  // White pixel turns black when any neighbor, itself included, is black.
  always_comb begin
    center    = c1.mid;
    any_black = (lcol.top == PIX_BLACK) || (lcol.mid == PIX_BLACK) ||
                (lcol.bot == PIX_BLACK) || (rcol.top == PIX_BLACK) ||
                (rcol.mid == PIX_BLACK) || (rcol.bot == PIX_BLACK) ||
                (center == PIX_BLACK) ||
                ((b_item.top ? center : c1.top) == PIX_BLACK) ||
                ((b_item.bottom ? center : c1.bot) == PIX_BLACK);
    result    = ((center == PIX_WHITE) && any_black) ? PIX_BLACK : center;
  end

  // Stage control, window shift and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (load) begin
        b_valid <= 1'b1;
      end else if (b_fire) begin
        b_valid <= 1'b0;
      end
      if (b_fire && b_item.emit) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (load) begin
      b_item <= item_in;
    end
    if (b_fire) begin
      c0 <= c1;
      c1 <= rc;
    end
    if (b_fire && b_item.emit) begin
      pixel_out  <= result;
      frame_last <= b_item.last;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/erode_white_3x3_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// erode_white_3x3_top: streaming 3x3 erosion of white pixels
// Raster-order grayscale filter: a pixel of 255 becomes 0 when any pixel of
// its edge-clamped 3x3 neighborhood is 0; all other pixels pass unchanged.
//
// Input channel (item_valid / item_stall): one word per cycle, cmd selects a
// pixel or a flush tick. Output channel (result_valid / result_stall) gives
// the filtered pixel and frame_last on the final pixel of the frame.
// Results come in raster order, image_width+1 words behind the input (one
// less for a single-row frame); after the last pixel, flush words drain the
// pending results. Words that cause no result are simply absorbed.
// A word is held in the window stage, and its result in the output register.
// One word is accepted every cycle unless stalled; the line buffer takes one
// read and one write per cycle, with a same-cycle write forwarded to the read.
// A stalled result holds in the output register; the window stage still
// takes one more word before item_stall rises.
// Reset sets the size to 640 x 480 and starts a new frame; the line buffer
// needs no clearing. A size register write (cfg_valid / cfg_ready, always
// ready) restarts the frame; the user, not the block, issues it only if idle.
// ----------------------------------------------------------------------------
module erode_white_3x3_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [ew3_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ew3_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          item_valid,
  output      logic                          item_stall,
  input  wire logic                          cmd,
  input  wire logic [ew3_pkg::PIX_W-1:0]     pixel_in,
  output      logic                          result_valid,
  input  wire logic                          result_stall,
  output      logic [ew3_pkg::PIX_W-1:0]     pixel_out,
  output      logic                          frame_last
);
  import ew3_pkg::*;

  logic         stage_free;
  logic         load;
  ew3_item_t    item;
  col_t         rd_addr;
  ew3_wr_t      wr;
  ew3_lb_word_t rd_data;

  assign item_stall = !stage_free;

  // Frame position control and size registers.
  ew3_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .stage_free (stage_free),
    .cmd        (cmd),
    .pixel_in   (pixel_in),
    .load       (load),
    .item       (item),
    .rd_addr    (rd_addr)
  );

  // Two-row line buffer.
  ew3_line_buf u_line_buf (
    .clk     (clk),
    .rd_en   (load),
    .rd_addr (rd_addr),
    .wr      (wr),
    .rd_data (rd_data)
  );

  // Window, erosion rule and result register.
  ew3_window u_window (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .item_in      (item),
    .rd_data      (rd_data),
    .result_stall (result_stall),
    .stage_free   (stage_free),
    .wr           (wr),
    .result_valid (result_valid),
    .pixel_out    (pixel_out),
    .frame_last   (frame_last)
  );

endmodule
`default_nettype wire

// ----- test/tb_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the streaming 3x3 white erosion filter
// Feeds pixel and flush words through the item channel under random idle
// and stall, predicts every filtered pixel and its frame_last flag with a
// behavioral line store of its own, and compares each result word in order.
// A short directed table covers the corner cases. Extreme and random frame
// sizes follow, with clean frames, noisy frames and abandoned frames.
// ----------------------------------------------------------------------------
module tb_top;
  import ew3_pkg::*;

  localparam int HIST_DEPTH     = 2 * MAX_WIDTH + 4;
  localparam int ITEM_GOAL      = 1300;
  localparam int SETTLE_CYCLES  = 8;
  localparam int END_CYCLES     = 12;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DIR_ROWS       = 25;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;
  typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_GIVEN} exp_mode_t;

  // One line of the directed table: a register write or an item word.
  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_W-1:0]      val;
    logic                  word_cmd;
    exp_mode_t             mode;
    pixel_t                want_pix;
    logic                  want_last;
  } dir_row_t;

  typedef struct packed {
    pixel_t pix;
    logic   last;
  } filt_word_t;

  logic                 clk;
  logic                 rst          = 1'b1;
  logic                 cfg_valid    = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index    = '0;
  logic [CFG_W-1:0]     cfg_data     = '0;
  logic                 item_valid   = 1'b0;
  logic                 item_stall;
  logic                 cmd          = CMD_PIXEL;
  pixel_t               pixel_in     = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  pixel_t               pixel_out;
  logic                 frame_last;

  erode_white_3x3_top DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .cmd          (cmd),
    .pixel_in     (pixel_in),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .pixel_out    (pixel_out),
    .frame_last   (frame_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Predicted filter state: size registers, pixel history and frame position.
  logic [CFG_W-1:0]  set_width  = WIDTH_RESET;
  logic [CFG_W-1:0]  set_height = HEIGHT_RESET;
  bit   [PIX_W-1:0]  hist [HIST_DEPTH];
  int unsigned       in_col;
  int unsigned       in_line;
  int unsigned       pend_cnt;
  int unsigned       out_pos;

  filt_word_t filtered_q [$];
  int         err_count  = 0;
  int         live_items = 0;
  bit         tx_idle    = 1'b1;
  bit         rx_idle    = 1'b1;

  function automatic int unsigned frame_w();
    if (set_width == '0) return 1;
    if (set_width > MAX_WIDTH) return MAX_WIDTH;
    return 32'(set_width);
  endfunction

  function automatic int unsigned frame_h();
    if (set_height == '0) return 1;
    if (set_height > MAX_HEIGHT) return MAX_HEIGHT;
    return 32'(set_height);
  endfunction

  function automatic void restart_frame_pos();
    in_col   = 0;
    in_line  = 0;
    pend_cnt = 0;
    out_pos  = 0;
  endfunction

  function automatic pixel_t hist_at(int unsigned r, int unsigned c, int unsigned w);
    return hist[(r * w + c) % HIST_DEPTH];
  endfunction

  // Produce the next output pixel in raster order. A white pixel turns black
  // when any pixel of its edge-clamped 3x3 neighborhood is black.
  function automatic void emit_next(output pixel_t px, output logic lst);
    int unsigned w, h, total, pr, pc, r0, r2, c0, c2;
    w     = frame_w();
    h     = frame_h();
    total = w * h;
    pr    = out_pos / w;
    pc    = out_pos % w;
    px    = hist_at(pr, pc, w);
    if (px == PIX_WHITE) begin
      r0 = (pr > 0) ? pr - 1 : 0;
      r2 = (pr + 1 < h) ? pr + 1 : h - 1;
      c0 = (pc > 0) ? pc - 1 : 0;
      c2 = (pc + 1 < w) ? pc + 1 : w - 1;
      for (int unsigned r = r0; r <= r2; r++) begin
        for (int unsigned c = c0; c <= c2; c++) begin
          if (hist_at(r, c, w) == PIX_BLACK) px = PIX_BLACK;
        end
      end
    end
    lst = (out_pos + 1 == total);
    out_pos++;
    if (pend_cnt > 0) pend_cnt--;
    if (out_pos >= total) restart_frame_pos();
  endfunction

  // Advance the predicted state by one item word. Returns 1 when the word
  // gives a result; live is 0 when the block ignores the word.
  function automatic bit erode_predict(input logic word_cmd, input pixel_t pix,
                                       output bit live, output pixel_t px,
                                       output logic lst);
    int unsigned w, h;
    bit          done;
    w    = frame_w();
    h    = frame_h();
    done = (in_line >= h);
    live = 1'b0;
    px   = '0;
    lst  = 1'b0;
    if (word_cmd == CMD_PIXEL) begin
      if (done) return 1'b0;
      live = 1'b1;
      hist[(in_line * w + in_col) % HIST_DEPTH] = pix;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_line++;
      end
      pend_cnt++;
      if (pend_cnt >= w + 2) begin
        emit_next(px, lst);
        return 1'b1;
      end
      return 1'b0;
    end
    if (!done || pend_cnt == 0) return 1'b0;
    live = 1'b1;
    emit_next(px, lst);
    return 1'b1;
  endfunction

  function automatic pixel_t rand_pixel();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return PIX_WHITE;
    if (pick < 6) return PIX_BLACK;
    if (pick == 6) return pixel_t'(PIX_WHITE - 1);
    if (pick == 7) return pixel_t'(PIX_BLACK + 1);
    return pixel_t'($urandom_range(0, 255));
  endfunction

  // Send one item word, then record what it is expected to produce.
  task automatic push_item(input logic word_cmd, input pixel_t pix,
                           input exp_mode_t mode, input pixel_t want_pix,
                           input logic want_last);
    int         gap;
    bit         has, live;
    pixel_t     px;
    logic       lst;
    filt_word_t w;
    gap = tx_idle ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    cmd        <= word_cmd;
    pixel_in   <= pix;
    do @(posedge clk); while (item_stall);
    has = erode_predict(word_cmd, pix, live, px, lst);
    if (live) live_items++;
    if (mode == EXP_MODEL && has) begin
      w = '{pix: px, last: lst};
      filtered_q.push_back(w);
    end else if (mode == EXP_GIVEN) begin
      w = '{pix: want_pix, last: want_last};
      filtered_q.push_back(w);
    end
  endtask

  // Write one size register once the block has gone quiet.
  task automatic write_setting(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_W-1:0] val);
    item_valid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_WIDTH) set_width = val;
    else if (idx == CFG_HEIGHT) set_height = val;
    restart_frame_pos();
  endtask

  // Finish whatever frame is in progress: remaining pixels, then flushes.
  task automatic drain_frame();
    while ((in_col != 0 || in_line != 0) && in_line < frame_h())
      push_item(CMD_PIXEL, rand_pixel(), EXP_MODEL, '0, 1'b0);
    while (pend_cnt != 0) push_item(CMD_FLUSH, rand_pixel(), EXP_MODEL, '0, 1'b0);
  endtask

  // One size setting followed by a few frames of mixed style.
  task automatic run_phase(input logic [CFG_W-1:0] w_raw, input logic [CFG_W-1:0] h_raw,
                           input bit set_w, input bit set_h, input int frames,
                           input bit clean_only);
    int unsigned total, style, n;
    if (set_w) write_setting(CFG_WIDTH, w_raw);
    if (set_h) write_setting(CFG_HEIGHT, h_raw);
    for (int f = 0; f < frames; f++) begin
      total = frame_w() * frame_h();
      style = clean_only ? 9 : $urandom_range(0, 9);
      if (style == 0) begin
        // Noise: random mix of pixels and flushes, some of them ignored.
        n = total + frame_w() + 4;
        for (int unsigned i = 0; i < n; i++)
          push_item(($urandom_range(0, 2) == 0) ? CMD_FLUSH : CMD_PIXEL, rand_pixel(),
                    EXP_MODEL, '0, 1'b0);
        drain_frame();
      end else if (style == 1) begin
        // Abandoned frame: the next register write restarts it.
        n = $urandom_range(1, total);
        for (int unsigned i = 0; i < n; i++)
          push_item(CMD_PIXEL, rand_pixel(), EXP_MODEL, '0, 1'b0);
        if ($urandom_range(0, 1) == 1) push_item(CMD_PIXEL, rand_pixel(), EXP_MODEL, '0, 1'b0);
        return;
      end else begin
        for (int unsigned i = 0; i < total; i++)
          push_item(CMD_PIXEL, rand_pixel(), EXP_MODEL, '0, 1'b0);
        drain_frame();
      end
    end
  endtask

  // Directed table. Expected words are typed in where they are obvious.
  dir_row_t dir_rows [DIR_ROWS] = '{
    // Reset size 640 x 480: a flush before the frame is complete is ignored.
    '{ROW_ITEM, CFG_WIDTH,  11'd0,    CMD_FLUSH, EXP_NONE,  8'd0,   1'b0},
    '{ROW_ITEM, CFG_WIDTH,  11'd255,  CMD_PIXEL, EXP_NONE,  8'd0,   1'b0},
    // Single-pixel frame: the pixel is its own neighborhood.
    '{ROW_CFG,  CFG_WIDTH,  11'd1,    CMD_PIXEL, EXP_NONE,  8'd0,   1'b0},
    '{ROW_CFG,  CFG_HEIGHT, 11'd1,    CMD_PIXEL, EXP_NONE,  8'd0,   1'b0},
    '{ROW_ITEM, CFG_WIDTH,  11'd255,  CMD_PIXEL, EXP_NONE,  8'd0,   1'b0},
    '{ROW_ITEM, CFG_WIDTH,  11'd0,    CMD_FLUSH, EXP_GIVEN, 8'd255, 1'b1},
    '{ROW_ITEM, CFG_WIDTH,  11'd0,    CMD_PIXEL, EXP_NONE,  8'd0,   1'b0},
    '{ROW_ITEM, CFG_WIDTH,  11'd0,    CMD_FLUSH, EXP_GIVEN, 8'd0,   1'b1},
    // The frame has ended, so this flush belongs to a new frame and is ignored.
    '{ROW_ITEM, CFG_WIDTH,  11'd0,    CMD_FLUSH, EXP_NONE,  8'd0,   1'b0},
    // Zero sizes act as one.
    '{ROW_CFG,  CFG_WIDTH,  11'd0,    CMD_PIXEL, EXP_NONE,  8'd0,   1'b0},
    '{ROW_CFG,  CFG_HEIGHT, 11'd0,    CMD_PIXEL, EXP_NONE,  8'd0,   1'b0},
    '{ROW_ITEM, CFG_WIDTH,  11'd128,  CMD_PIXEL, EXP_NONE,  8'd0,   1'b0},
    '{ROW_ITEM, CFG_WIDTH,  11'd0,    CMD_FLUSH, EXP_GIVEN, 8'd128, 1'b1},
    // A 3 x 2 frame with white, near-white, black and near-black pixels.
    '{ROW_CFG,  CFG_WIDTH,  11'd3,    CMD_PIXEL, EXP_NONE,  8'd0,   1'b0},
    '{ROW_CFG,  CFG_HEIGHT, 11'd2,    CMD_PIXEL, EXP_NONE,  8'd0,   1'b0},
    '{ROW_ITEM, CFG_WIDTH,  11'd255,  CMD_PIXEL, EXP_MODEL, 8'd0,   1'b0},
    '{ROW_ITEM, CFG_WIDTH,  11'd255,  CMD_PIXEL, EXP_MODEL, 8'd0,   1'b0},
    '{ROW_ITEM, CFG_WIDTH,  11'd1,    CMD_PIXEL, EXP_MODEL, 8'd0,   1'b0},
    '{ROW_ITEM, CFG_WIDTH,  11'd254,  CMD_PIXEL, EXP_MODEL, 8'd0,   1'b0},
    '{ROW_ITEM, CFG_WIDTH,  11'd0,    CMD_PIXEL, EXP_MODEL, 8'd0,   1'b0},
    '{ROW_ITEM, CFG_WIDTH,  11'd255,  CMD_PIXEL, EXP_MODEL, 8'd0,   1'b0},
    // A pixel after the complete frame input is ignored while outputs pend.
    '{ROW_ITEM, CFG_WIDTH,  11'd77,   CMD_PIXEL, EXP_NONE,  8'd0,   1'b0},
    '{ROW_ITEM, CFG_WIDTH,  11'd0,    CMD_FLUSH, EXP_MODEL, 8'd0,   1'b0},
    '{ROW_ITEM, CFG_WIDTH,  11'd0,    CMD_FLUSH, EXP_MODEL, 8'd0,   1'b0},
    '{ROW_ITEM, CFG_WIDTH,  11'd0,    CMD_FLUSH, EXP_MODEL, 8'd0,   1'b0}
  };

  // Main stimulus: reset, directed table, extreme sizes, random phases.
  initial begin : stimulus
    int unsigned wr, hr, mask;
    restart_frame_pos();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_rows[i].kind == ROW_CFG)
        write_setting(dir_rows[i].idx, dir_rows[i].val);
      else
        push_item(dir_rows[i].word_cmd, dir_rows[i].val[PIX_W-1:0], dir_rows[i].mode,
                  dir_rows[i].want_pix, dir_rows[i].want_last);
    end
    // The directed table leaves one flush of the 3 x 2 frame outstanding.
    drain_frame();

    // A one-column frame whose height is above the maximum and saturates.
    run_phase(11'd1,    11'd2047, 1'b1, 1'b1, 1, 1'b1);

    // Random phases until the word count of the whole run reaches the goal.
    while (live_items < ITEM_GOAL) begin
      wr = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
      hr = $urandom_range(0, 8);
      mask = $urandom_range(0, 5);
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      run_phase(CFG_W'(wr), CFG_W'(hr), mask != 1, mask != 2, $urandom_range(1, 3), 1'b0);
    end

    item_valid <= 1'b0;
    while (filtered_q.size() != 0) @(posedge clk);
    repeat (END_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Result side: random stall per word, then compare with the oldest prediction.
  initial begin : result_check
    int         k;
    filt_word_t want;
    wait (!rst);
    forever begin
      k = rx_idle ? $urandom_range(0, 4) : 0;
      if (k > 0) begin
        result_stall <= 1'b1;
        repeat (k) @(posedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!result_valid);
      if (filtered_q.size() == 0) begin
        $error("unexpected result word: pixel_out %0d frame_last %0b", pixel_out, frame_last);
        err_count++;
      end else begin
        want = filtered_q.pop_front();
        if (pixel_out !== want.pix) begin
          $error("pixel_out: expected %0d, got %0d", want.pix, pixel_out);
          err_count++;
        end
        if (frame_last !== want.last) begin
          $error("frame_last: expected %0b, got %0b", want.last, frame_last);
          err_count++;
        end
      end
    end
  end

  // Watchdog: ends the run when no word moves on any channel for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((item_valid && !item_stall) || (result_valid && !result_stall) ||
          (cfg_valid && cfg_ready) || rst) begin
        quiet = 0;
      end else begin
        quiet++;
      end
      if (quiet >= WATCHDOG_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

endmodule
`default_nettype wire
